>>> design/apq_pkg.sv
`timescale 1ns / 1ps
// apq_pkg: operation and status codes, controller command and status structs
// used by apq_ctrl, apq_datapath and array_priority_queue_top; no dependencies

package apq_pkg;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    typedef enum logic [1:0] {
        ST_ENQUEUED = 2'd0,
        ST_FULL     = 2'd1,
        ST_DEQUEUED = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    typedef struct packed {
        logic accept;     // latch input beat, arm the scan
        logic scan_step;  // compare one more entry
        logic commit;     // apply the operation, load the result register
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } t_stat;

endpackage

>>> design/apq_if.sv
`timescale 1ns / 1ps
// apq_in_if and apq_out_if: valid/ready channels of the priority queue
// payload widths fixed by the request and result formats; no dependencies

interface apq_in_if;
    logic               valid;
    logic               ready;
    logic               operation;
    logic signed [31:0] value;
    logic        [7:0]  priority_req;

    modport source (output valid, operation, value, priority_req, input ready);
    modport sink   (input valid, operation, value, priority_req, output ready);
endinterface

interface apq_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] item;
    logic        [1:0]  status;
    logic        [3:0]  occupancy;

    modport source (output valid, item, status, occupancy, input ready);
    modport sink   (input valid, item, status, occupancy, output ready);
endinterface

>>> design/apq_ctrl.sv
`timescale 1ns / 1ps
// apq_ctrl: sequencer for accept, priority scan and commit
// depends on apq_pkg for the command and status structs

module apq_ctrl import apq_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_in_op,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_EXEC = 3'b100
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = (i_in_op == OP_DEQ) ? S_SCAN : S_EXEC;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = S_EXEC;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_EXEC: begin
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    a_scan_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.scan_step |-> (r_state == S_SCAN && !i_stat.scan_done))
        else $error("scan step outside scan");

    a_commit_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> o_in_ready)
        else $error("not ready after commit");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> !o_in_ready)
        else $error("still idle after accept");

endmodule

>>> design/apq_datapath.sv
`timescale 1ns / 1ps
// apq_datapath: entry registers, scan compare, gap-closing shift, result register
// depends on apq_pkg; driven by apq_ctrl commands

module apq_datapath import apq_pkg::*; #(
    parameter int DEPTH     = 8,
    parameter int PRIO_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    input  logic               i_op,
    input  logic signed [31:0] i_value,
    input  logic        [7:0]  i_priority_req,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic signed [31:0] o_item,
    output logic        [1:0]  o_status,
    output logic        [3:0]  o_occupancy
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic signed [31:0]    r_val [DEPTH];
    logic [PRIO_BITS-1:0]  r_pri [DEPTH];
    logic [CW-1:0]         r_count;
    logic                  r_op;
    logic signed [31:0]    r_in_val;
    logic [PRIO_BITS-1:0]  r_in_pri;
    logic [IW-1:0]         r_best;
    logic [PRIO_BITS-1:0]  r_best_pri;
    logic [CW-1:0]         r_idx;
    logic                  r_out_valid;
    logic signed [31:0]    r_item;
    t_status               r_status;
    logic [CW-1:0]         r_occ;

    logic [PRIO_BITS-1:0]  scan_pri;
    logic                  is_full;
    logic                  is_empty;

    assign scan_pri = r_pri[r_idx[IW-1:0]];
    assign is_full  = (r_count == CW'(DEPTH));
    assign is_empty = (r_count == '0);

    assign o_stat.scan_done = (r_idx >= r_count);
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    // scan state and latched request
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op       <= i_op;
            r_in_val   <= i_value;
            r_in_pri   <= PRIO_BITS'(32'(i_priority_req));
            r_best     <= '0;
            r_best_pri <= r_pri[0];
            r_idx      <= CW'(1);
        end else if (i_cmd.scan_step) begin
            if (scan_pri > r_best_pri) begin
                r_best     <= r_idx[IW-1:0];
                r_best_pri <= scan_pri;
            end
            r_idx <= r_idx + CW'(1);
        end
    end

    // entry store: append at tail, close the gap on removal
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (r_op == OP_ENQ) begin
                    if (!is_full && CW'(i) == r_count) begin
                        r_val[i] <= r_in_val;
                        r_pri[i] <= r_in_pri;
                    end
                end else if (i < DEPTH - 1 && IW'(i) >= r_best) begin
                    r_val[i] <= r_val[(i + 1) % DEPTH];
                    r_pri[i] <= r_pri[(i + 1) % DEPTH];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.commit) begin
            if (r_op == OP_ENQ && !is_full) begin
                r_count <= r_count + CW'(1);
            end else if (r_op == OP_DEQ && !is_empty) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_item <= '0;
            r_occ  <= r_count;
            if (r_op == OP_ENQ) begin
                if (is_full) begin
                    r_status <= ST_FULL;
                end else begin
                    r_status <= ST_ENQUEUED;
                    r_occ    <= r_count + CW'(1);
                end
            end else begin
                if (is_empty) begin
                    r_status <= ST_EMPTY;
                end else begin
                    r_status <= ST_DEQUEUED;
                    r_item   <= r_val[r_best];
                    r_occ    <= r_count - CW'(1);
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_item      = r_item;
    assign o_status    = r_status;
    assign o_occupancy = 4'(r_occ);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count beyond depth");

    a_commit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> o_stat.out_free)
        else $error("result register overwritten");

    a_deq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_op == OP_DEQ && !is_empty)
            |=> (r_count == $past(r_count) - CW'(1)))
        else $error("dequeue did not drop count");

    a_occ_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> (r_occ == r_count))
        else $error("reported occupancy differs from count");

endmodule

>>> design/array_priority_queue_top.sv
`timescale 1ns / 1ps
// array_priority_queue_top: bounded priority queue, oldest entry wins on ties
// depends on apq_pkg, apq_if, apq_ctrl and apq_datapath
//
//  channel | dir | beat payload                       | handshake
//  i_in    | in  | operation, value, priority_req     | valid && ready
//  o_out   | out | item, status, occupancy            | valid && ready
//
// an enqueue, stored or full, goes from accept straight to commit, skipping the scan
// a dequeue scans every stored entry before commit, one compare per scan cycle
// one request in flight; the next is taken while the result still waits
// reset clears the entry count and the result valid; entries need no clearing
// a stalled result holds the commit step until the result register frees

module array_priority_queue_top import apq_pkg::*; #(
    parameter int DEPTH     = 8,
    parameter int PRIO_BITS = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    apq_in_if.sink    i_in,
    apq_out_if.source o_out
);

    t_cmd  cmd;
    t_stat stat;

    apq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_op    (i_in.operation),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    apq_datapath #(
        .DEPTH     (DEPTH),
        .PRIO_BITS (PRIO_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_op           (i_in.operation),
        .i_value        (i_in.value),
        .i_priority_req (i_in.priority_req),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_item         (o_out.item),
        .o_status       (o_out.status),
        .o_occupancy    (o_out.occupancy)
    );

endmodule

>>> sim/array_priority_queue_top_tb.sv
`timescale 1ns / 1ps
// array_priority_queue_top_tb: self-checking bench for the bounded priority queue
// depends on apq_pkg, apq_if and array_priority_queue_top; predicts every result beat

module array_priority_queue_top_tb;
    import apq_pkg::*;

    localparam int DEPTH          = 8;
    localparam int PRIO_BITS      = 8;
    localparam logic [7:0] PRIO_MASK = 8'((64'd1 << PRIO_BITS) - 64'd1);
    localparam int RANDOM_PER_PHASE = 275;
    localparam int DRAIN_CYCLES   = 40;

    typedef struct {
        logic               operation;
        logic signed [31:0] value;
        logic        [7:0]  priority_req;
    } t_request;

    typedef struct {
        logic signed [31:0] item;
        t_status            status;
        logic        [3:0]  occupancy;
    } t_outcome;

    logic i_clk;
    logic i_rst_n;

    apq_in_if  in_if ();
    apq_out_if out_if ();

    array_priority_queue_top #(
        .DEPTH     (DEPTH),
        .PRIO_BITS (PRIO_BITS)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_request    request_backlog[$];
    t_outcome    awaited_outcomes[$];
    logic [31:0] held_value[DEPTH];
    logic [7:0]  held_prio[DEPTH];
    int          held_count;
    int          issued_count;
    int          accepted_count;
    int          error_count;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          plan_count;

    // shadow queue: applies one request, returns the beat it should produce
    function automatic t_outcome queue_apply(t_request req);
        t_outcome res;
        int       best;
        res.item = '0;
        if (req.operation == OP_ENQ) begin
            if (held_count >= DEPTH) begin
                res.status = ST_FULL;
            end else begin
                held_value[held_count] = req.value;
                held_prio[held_count]  = req.priority_req & PRIO_MASK;
                held_count++;
                res.status = ST_ENQUEUED;
            end
        end else if (held_count == 0) begin
            res.status = ST_EMPTY;
        end else begin
            best = 0;
            for (int i = 1; i < held_count; i++) begin
                if (held_prio[i] > held_prio[best]) best = i;
            end
            res.item = held_value[best];
            for (int i = best; i + 1 < held_count; i++) begin
                held_value[i] = held_value[i + 1];
                held_prio[i]  = held_prio[i + 1];
            end
            held_count--;
            res.status = ST_DEQUEUED;
        end
        res.occupancy = 4'(held_count);
        return res;
    endfunction

    task automatic queue_request(logic op, logic [31:0] val, logic [7:0] prio);
        t_request req;
        req.operation    = op;
        req.value        = val;
        req.priority_req = prio;
        request_backlog.push_back(req);
        issued_count++;
        if (op == OP_ENQ) begin
            if (plan_count < DEPTH) plan_count++;
        end else if (plan_count > 0) begin
            plan_count--;
        end
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (accepted_count < issued_count || awaited_outcomes.size() != 0);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(19))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [7:0] pick_prio();
        int roll;
        roll = $urandom_range(99);
        if (roll < 40) return 8'($urandom_range(3));
        if (roll < 45) return 8'h00;
        if (roll < 50) return 8'hff;
        return 8'($urandom_range(255));
    endfunction

    initial begin
        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        in_if.valid        = 1'b0;
        in_if.operation    = OP_ENQ;
        in_if.value        = '0;
        in_if.priority_req = '0;
        out_if.ready       = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                awaited_outcomes.push_back(queue_apply('{in_if.operation, in_if.value,
                                                         in_if.priority_req}));
                accepted_count++;
            end
            if (!in_if.valid || in_if.ready) begin
                if (request_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_if.valid        <= 1'b1;
                    in_if.operation    <= request_backlog[0].operation;
                    in_if.value        <= request_backlog[0].value;
                    in_if.priority_req <= request_backlog[0].priority_req;
                    void'(request_backlog.pop_front());
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
            if (out_if.valid && out_if.ready) begin
                if (awaited_outcomes.size() == 0) begin
                    $error("result beat with nothing awaited: item %0d status %0d occupancy %0d",
                           out_if.item, out_if.status, out_if.occupancy);
                    error_count++;
                end else begin
                    if (out_if.item !== awaited_outcomes[0].item) begin
                        $error("item: expected %0d, got %0d",
                               awaited_outcomes[0].item, out_if.item);
                        error_count++;
                    end
                    if (out_if.status !== awaited_outcomes[0].status) begin
                        $error("status: expected %0d, got %0d",
                               awaited_outcomes[0].status, out_if.status);
                        error_count++;
                    end
                    if (out_if.occupancy !== awaited_outcomes[0].occupancy) begin
                        $error("occupancy: expected %0d, got %0d",
                               awaited_outcomes[0].occupancy, out_if.occupancy);
                        error_count++;
                    end
                    void'(awaited_outcomes.pop_front());
                end
            end
        end
    end

    initial begin
        int enq_bias;
        int run_left;
        held_count     = 0;
        issued_count   = 0;
        accepted_count = 0;
        error_count    = 0;
        plan_count     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        enq_bias       = 50;
        run_left       = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty, full, ties, extremes, single entry
        queue_request(OP_DEQ, 32'hdead_beef, 8'hff);
        queue_request(OP_ENQ, 32'h7fff_ffff, 8'h00);
        queue_request(OP_ENQ, 32'h8000_0000, 8'hff);
        queue_request(OP_ENQ, 32'h0000_0000, 8'hff);
        queue_request(OP_ENQ, 32'hffff_ffff, 8'h80);
        queue_request(OP_ENQ, 32'h5555_5555, 8'h01);
        queue_request(OP_ENQ, 32'haaaa_aaaa, 8'hff);
        queue_request(OP_ENQ, 32'd12345, 8'h00);
        queue_request(OP_ENQ, -32'sd42, 8'hfe);
        queue_request(OP_ENQ, 32'h0f0f_0f0f, 8'hc8);
        repeat (8) queue_request(OP_DEQ, $urandom, 8'($urandom_range(255)));
        queue_request(OP_DEQ, 32'h0, 8'h00);
        queue_request(OP_ENQ, 32'h1234_5678, 8'h7f);
        queue_request(OP_DEQ, 32'hffff_ffff, 8'h00);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            // filling, draining and mixed runs so full and empty recur often
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                if (run_left == 0) begin
                    case ($urandom_range(2))
                        0: enq_bias = 85;
                        1: enq_bias = 15;
                        default: enq_bias = 50;
                    endcase
                    run_left = $urandom_range(24, 4);
                end
                run_left--;
                if ($urandom_range(99) < enq_bias)
                    queue_request(OP_ENQ, pick_value(), pick_prio());
                else
                    queue_request(OP_DEQ, $urandom, 8'($urandom_range(255)));
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (error_count == 0 && awaited_outcomes.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> array_priority_queue_top.f
design/apq_pkg.sv
design/apq_if.sv
design/apq_ctrl.sv
design/apq_datapath.sv
design/array_priority_queue_top.sv
sim/array_priority_queue_top_tb.sv
